/* rtl/glos_pkg.sv */
// Package for the grid line-of-sight unit: types, codes, constants and the
// tile walkability test. No dependencies.
`default_nettype none

package glos_pkg;

  // Map defaults (overridable on the top level)
  localparam int MAP_COLS_DEF    = 32;
  localparam int MAP_ROWS_DEF    = 32;
  localparam int TILE_PIXELS_DEF = 16;
  localparam int LEVEL_COUNT_DEF = 4;

  // Fixed field widths
  localparam int PIX_W   = 11;  // signed pixel coordinate
  localparam int TCOL_W  = 5;   // write column
  localparam int TROW_W  = 5;   // write row
  localparam int TYPE_W  = 8;   // tile type code
  localparam int LEVEL_W = 2;   // active_level register
  localparam int DIFF_W  = PIX_W + 1;  // tile coordinate difference
  localparam int ERR_W   = PIX_W + 3;  // Bresenham error term and its double

  // Reciprocal scaling for the pixel to tile division
  localparam int DIV_SHIFT = 24;

  // Extra walkable tile type besides 0 and 1
  localparam logic [TYPE_W-1:0] WALK_TYPE_EXTRA = 8'd82;

  // Operation codes of the func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } glos_state_t;

  function automatic logic walkable(input logic [TYPE_W-1:0] t);
    return (t == TYPE_W'(0)) || (t == TYPE_W'(1)) || (t == WALK_TYPE_EXTRA);
  endfunction

endpackage

`default_nettype wire

/* rtl/glos_ifs.sv */
// Channel interfaces of the grid line-of-sight unit: request, result and
// configuration write. Depends on glos_pkg.
`default_nettype none

interface glos_req_if;
  import glos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [TCOL_W-1:0]        tile_col;
  logic [TROW_W-1:0]        tile_row;
  logic [TYPE_W-1:0]        tile_type;
  logic signed [PIX_W-1:0]  start_x;
  logic signed [PIX_W-1:0]  start_y;
  logic signed [PIX_W-1:0]  end_x;
  logic signed [PIX_W-1:0]  end_y;

  modport source (output valid, func, tile_col, tile_row, tile_type,
                  start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, tile_col, tile_row, tile_type,
                  start_x, start_y, end_x, end_y, output ready);
endinterface

interface glos_rsp_if;
  logic valid;
  logic ready;
  logic line_clear;

  modport source (output valid, line_clear, input ready);
  modport sink   (input valid, line_clear, output ready);
endinterface

interface glos_cfg_if;
  import glos_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] active_level;

  modport source (output valid, active_level, input ready);
  modport sink   (input valid, active_level, output ready);
endinterface

`default_nettype wire

/* rtl/grid_line_of_sight_unit.sv */
// Grid line-of-sight unit: per-level tile map in one synchronous memory and
// a Bresenham walk that reads one tile per cycle. Depends on glos_pkg, glos_ifs.
// Write word: no result. Query word: pixel-to-tile scaling of the four
// coordinates (one shared multiplier), a setup step, the walk over the tiles
// on the line (one memory read port), then a drain and a result step.
// A blocked or off-map tile ends the walk early. One query at a time.
// Reset (rst, synchronous): clears control state and active_level; the tile
// memory is not cleared and holds no data until written.
`default_nettype none

module grid_line_of_sight_unit #(
  parameter int MAP_COLS    = glos_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS    = glos_pkg::MAP_ROWS_DEF,
  parameter int TILE_PIXELS = glos_pkg::TILE_PIXELS_DEF,
  parameter int LEVEL_COUNT = glos_pkg::LEVEL_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  glos_req_if.sink   req,
  glos_rsp_if.source rsp,
  glos_cfg_if.sink   cfg
);
  import glos_pkg::*;

  localparam int COL_W  = $clog2(MAP_COLS);
  localparam int ROW_W  = $clog2(MAP_ROWS);
  localparam int LVL_W  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int ADDR_W = LVL_W + ROW_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int RECIP_W = DIV_SHIFT + 1;
  localparam int PROD_W  = PIX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** DIV_SHIFT + TILE_PIXELS - 1) / TILE_PIXELS);

  glos_state_t state, state_next;

  logic [LEVEL_W-1:0]       active_level;
  logic [LVL_W-1:0]         lvl_idx;
  logic                     lvl_ok;

  // Query operands and walk registers
  logic signed [PIX_W-1:0]  pix_sx, pix_sy, pix_ex, pix_ey;
  logic [1:0]               div_idx;
  logic signed [PIX_W-1:0]  cx, cy, ex, ey;
  logic signed [ERR_W-1:0]  dx, dyn, err;
  logic                     sx_neg, sy_neg;
  logic                     clear_acc;

  // Tile memory
  logic [TYPE_W-1:0]        tile_mem [DEPTH];
  logic [TYPE_W-1:0]        rd_data;
  logic                     rd_pend;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     mem_re, mem_we;

  logic                     req_acc;
  logic                     in_map, at_end, blocked;

  // Divider datapath
  logic signed [PIX_W-1:0]  div_in;
  logic [PIX_W-1:0]         div_mag;
  logic [PROD_W-1:0]        div_prod;
  logic [PIX_W-1:0]         div_q;
  logic signed [PIX_W-1:0]  div_tile;

  // Setup and step datapath
  logic signed [DIFF_W-1:0] dxd, dyd;
  logic signed [ERR_W-1:0]  dx_abs, dy_abs;
  logic signed [ERR_W-1:0]  e2;
  logic                     step_x, step_y;

  assign lvl_idx = LVL_W'(active_level);
  assign lvl_ok  = int'(active_level) < LEVEL_COUNT;
  assign req_acc = req.valid && req.ready;

  // Walk status
  assign in_map  = (cx >= 0) && (int'(cx) < MAP_COLS) && (cy >= 0) && (int'(cy) < MAP_ROWS);
  assign at_end  = (cx == ex) && (cy == ey);
  assign blocked = rd_pend && !walkable(rd_data);

  // Pixel to tile: scaled reciprocal multiply on the magnitude, truncate toward zero
  always_comb begin
    unique case (div_idx)
      2'd0: div_in = pix_sx;
      2'd1: div_in = pix_sy;
      2'd2: div_in = pix_ex;
      default: div_in = pix_ey;
    endcase
    div_mag  = div_in[PIX_W-1] ? PIX_W'(-div_in) : PIX_W'(div_in);
    div_prod = PROD_W'(div_mag) * PROD_W'(RECIP);
    div_q    = div_prod[DIV_SHIFT +: PIX_W];
    div_tile = div_in[PIX_W-1] ? -$signed(div_q) : $signed(div_q);
  end

  // Span and Bresenham step decisions
  always_comb begin
    dxd    = DIFF_W'(ex) - DIFF_W'(cx);
    dyd    = DIFF_W'(ey) - DIFF_W'(cy);
    dx_abs = (dxd < 0) ? -ERR_W'(dxd) : ERR_W'(dxd);
    dy_abs = (dyd < 0) ? -ERR_W'(dyd) : ERR_W'(dyd);
    e2     = err <<< 1;
    step_x = e2 >= dyn;
    step_y = e2 <= dx;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && req.func == FUNC_QUERY) begin
          state_next = lvl_ok ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_idx == 2'd3) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        priority if (blocked || !in_map) begin
          state_next = ST_FINISH;
        end else if (at_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    req.ready = (state == ST_IDLE);
    cfg.ready = 1'b1;
    mem_re    = (state == ST_WALK) && in_map && !blocked;
    mem_we    = req_acc && (req.func == FUNC_WRITE) && lvl_ok &&
                (int'(req.tile_col) < MAP_COLS) && (int'(req.tile_row) < MAP_ROWS);
    rd_addr   = {lvl_idx, ROW_W'(cy), COL_W'(cx)};
    wr_addr   = {lvl_idx, ROW_W'(req.tile_row), COL_W'(req.tile_col)};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_level <= '0;
      rd_pend      <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_re;
      if (cfg.valid && cfg.ready) begin
        active_level <= cfg.active_level;
      end
      // Load the result word, or drop it once taken
      if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Tile memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[wr_addr] <= req.tile_type;
    end
    if (mem_re) begin
      rd_data <= tile_mem[rd_addr];
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        div_idx <= 2'd0;
        if (req_acc && req.func == FUNC_QUERY) begin
          pix_sx    <= req.start_x;
          pix_sy    <= req.start_y;
          pix_ex    <= req.end_x;
          pix_ey    <= req.end_y;
          clear_acc <= lvl_ok;
        end
      end
      ST_DIV: begin
        div_idx <= div_idx + 2'd1;
        unique case (div_idx)
          2'd0: cx <= div_tile;
          2'd1: cy <= div_tile;
          2'd2: ex <= div_tile;
          default: ey <= div_tile;
        endcase
      end
      ST_SETUP: begin
        dx     <= dx_abs;
        dyn    <= -dy_abs;
        err    <= dx_abs - dy_abs;
        sx_neg <= !(cx < ex);
        sy_neg <= !(cy < ey);
      end
      ST_WALK: begin
        // Advance one tile per cycle; the read of the previous tile is checked now
        if (blocked || !in_map) begin
          clear_acc <= 1'b0;
        end else if (!at_end) begin
          err <= err + (step_x ? dyn : ERR_W'(0)) + (step_y ? dx : ERR_W'(0));
          if (step_x) begin
            cx <= sx_neg ? cx - PIX_W'(1) : cx + PIX_W'(1);
          end
          if (step_y) begin
            cy <= sy_neg ? cy - PIX_W'(1) : cy + PIX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (blocked) begin
          clear_acc <= 1'b0;
        end
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.line_clear <= clear_acc;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/glos_check.sv */
// Port-level checker for the grid line-of-sight unit, bound to the top level.
// Depends on glos_pkg and grid_line_of_sight_unit.
`default_nettype none

module glos_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic req_func,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic line_clear
);
  import glos_pkg::*;

  // Hold the result word until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_clear))
    else $error("result word changed or dropped while stalled");

  // Drop request ready once a query is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_QUERY |=> !req_ready)
    else $error("request ready stayed high after a query word");

  // A write word never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_WRITE && !rsp_valid |=> !rsp_valid)
    else $error("result word appeared after a write word");

  // A new result appears only at the end of a busy period
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result word appeared while the unit was idle");

endmodule

bind grid_line_of_sight_unit glos_check u_glos_check (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_func   (req.func),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .line_clear (rsp.line_clear)
);

`default_nettype wire
